// ----- design/kst_pkg.sv -----
// Shared constants for the keyed slot table: opcodes, status codes,
// register indexes and reset values. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package kst_pkg;
    localparam int INDEX_BITS_DEF  = 10;
    localparam int FANOUT_BITS_DEF = 4;
    localparam int DATA_BITS_DEF   = 32;

    localparam int KEY_W        = 32;
    localparam int WORD_BITS    = 32;
    localparam int CFG_IDX_BITS = 1;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_ADD    = 2'd1,
        OP_REMOVE = 2'd2,
        OP_SEARCH = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_DENIED  = 2'd2,
        ST_ABSENT  = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_LOWEST  = 1'd0,
        REG_HIGHEST = 1'd1
    } cfg_reg_t;

    localparam logic [KEY_W-1:0] LOWEST_RESET  = 32'd0;
    localparam logic [KEY_W-1:0] HIGHEST_RESET = 32'd1023;
endpackage
`default_nettype wire

// ----- design/kst_if.sv -----
// Request and response channel interfaces for the keyed slot table.
// Depends on kst_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface kst_req_if import kst_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [1:0]           opcode;
    logic [KEY_W-1:0]     key;
    logic [WORD_BITS-1:0] value_in;
    modport source (output valid, opcode, key, value_in, input ready);
    modport sink   (input valid, opcode, key, value_in, output ready);
endinterface

interface kst_rsp_if import kst_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [1:0]           status;
    logic                 found;
    logic [WORD_BITS-1:0] value_out;
    logic [KEY_W-1:0]     free_key;
    modport source (output valid, status, found, value_out, free_key, input ready);
    modport sink   (input valid, status, found, value_out, free_key, output ready);
endinterface
`default_nettype wire

// ----- design/kst_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module kst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output      logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- design/keyed_slot_table_with_free_search.sv -----
// Keyed slot table with first-free search: sequencer, fill counters, config.
// Depends on kst_pkg, kst_if and kst_ram.
//
//  channel | dir | handshake   | payload
//  req     | in  | valid/ready | opcode, key, value_in
//  rsp     | out | valid/ready | status, found, value_out, free_key
//  cfg     | in  | cfg_we      | cfg_index, cfg_data
//
// Lookup, add and remove: accept, RAM read (S_READ), read-modify-write (S_EXEC),
// result stage (S_PUSH); req.ready returns once the result is in rsp. A search
// step reads in S_SRD and checks in S_SCHK (one slot, one skipped small or large
// group); past the upper key S_SRD gives up, then the result stage follows.
// After reset a clearing pass over every slot address zeroes the slot and small-group
// fill RAMs; req.ready stays low meanwhile. A stalled result holds in rsp.
`timescale 1ns / 1ps
`default_nettype none
module keyed_slot_table_with_free_search import kst_pkg::*; #(
    parameter int INDEX_BITS  = INDEX_BITS_DEF,
    parameter int FANOUT_BITS = FANOUT_BITS_DEF,
    parameter int DATA_BITS   = DATA_BITS_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    kst_req_if.sink                      req,
    kst_rsp_if.source                    rsp,
    input  wire logic                    cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [KEY_W-1:0]        cfg_data
);
    localparam int CAP     = 1 << INDEX_BITS;
    localparam int SS      = (FANOUT_BITS > INDEX_BITS) ? INDEX_BITS : FANOUT_BITS;
    localparam int BS      = (2 * FANOUT_BITS > INDEX_BITS) ? INDEX_BITS : 2 * FANOUT_BITS;
    localparam int SGROUPS = 1 << (INDEX_BITS - SS);
    localparam int BGROUPS = 1 << (INDEX_BITS - BS);
    localparam int SG_AW   = (INDEX_BITS - SS > 0) ? INDEX_BITS - SS : 1;
    localparam int BG_AW   = (INDEX_BITS - BS > 0) ? INDEX_BITS - BS : 1;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_READ, S_EXEC, S_SRD, S_SCHK, S_PUSH
    } state_t;

    state_t                 state_reg;
    logic [KEY_W-1:0]       lowest_reg, highest_reg;
    logic [KEY_W:0]         upper_reg;
    logic [INDEX_BITS:0]    sweep_reg;
    logic [1:0]             op_reg;
    logic [DATA_BITS-1:0]   data_reg;
    logic [INDEX_BITS:0]    idx_reg;
    logic [INDEX_BITS-1:0]  last_reg;
    logic                   inr_reg;
    logic [BS:0]            big_fill_reg [BGROUPS];
    logic [1:0]             res_status_reg;
    logic                   res_found_reg;
    logic [WORD_BITS-1:0]   res_value_reg;
    logic [KEY_W-1:0]       res_free_reg;
    logic                   out_valid_reg;
    logic [1:0]             out_status_reg;
    logic                   out_found_reg;
    logic [WORD_BITS-1:0]   out_value_reg;
    logic [KEY_W-1:0]       out_free_reg;

    logic [INDEX_BITS-1:0]  slot_addr, slot_waddr;
    logic [DATA_BITS-1:0]   slot_rdata, slot_wdata;
    logic                   slot_we;
    logic [SG_AW-1:0]       sg_raddr, sg_waddr;
    logic [SS:0]            sg_rdata, sg_wdata;
    logic                   sg_we;
    logic [BG_AW-1:0]       bg_idx;
    logic [63:0]            vin_wide, rd_wide;
    logic [DATA_BITS-1:0]   data_in;
    logic [KEY_W-1:0]       key_off;
    logic [KEY_W:0]         cap_top;
    logic                   slot_zero, do_add, do_rem;

    assign vin_wide  = {32'd0, req.value_in};
    assign data_in   = vin_wide[DATA_BITS-1:0];
    assign rd_wide   = 64'(slot_rdata);
    assign key_off   = req.key - lowest_reg;
    assign cap_top   = {1'b0, lowest_reg} + (KEY_W+1)'(CAP - 1);
    assign slot_zero = (slot_rdata == '0);
    assign bg_idx    = BG_AW'(idx_reg[INDEX_BITS-1:0] >> BS);

    assign do_add = (state_reg == S_EXEC) && inr_reg && (op_reg == OP_ADD)
                    && (data_reg != '0) && slot_zero;
    assign do_rem = (state_reg == S_EXEC) && inr_reg && (op_reg == OP_REMOVE) && !slot_zero;

    always_comb
    begin
        if (state_reg == S_CLEAR)
        begin
            slot_we    = 1'b1;
            slot_waddr = sweep_reg[INDEX_BITS-1:0];
            slot_wdata = '0;
            sg_we      = 1'b1;
            sg_waddr   = SG_AW'(sweep_reg[INDEX_BITS-1:0] >> SS);
            sg_wdata   = '0;
        end
        else
        begin
            slot_we    = do_add || do_rem;
            slot_waddr = idx_reg[INDEX_BITS-1:0];
            slot_wdata = do_add ? data_reg : '0;
            sg_we      = do_add || do_rem;
            sg_waddr   = SG_AW'(idx_reg[INDEX_BITS-1:0] >> SS);
            sg_wdata   = do_add ? sg_rdata + 1'b1 : sg_rdata - 1'b1;
        end
        slot_addr = idx_reg[INDEX_BITS-1:0];
        sg_raddr  = SG_AW'(idx_reg[INDEX_BITS-1:0] >> SS);
    end

    kst_ram #(.WIDTH(DATA_BITS), .DEPTH(CAP), .AW(INDEX_BITS)) u_slots (
        .clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
        .raddr(slot_addr), .rdata(slot_rdata)
    );

    kst_ram #(.WIDTH(SS + 1), .DEPTH(SGROUPS), .AW(SG_AW)) u_small_fill (
        .clk(clk), .we(sg_we), .waddr(sg_waddr), .wdata(sg_wdata),
        .raddr(sg_raddr), .rdata(sg_rdata)
    );

    assign req.ready     = (state_reg == S_IDLE);
    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.found     = out_found_reg;
    assign rsp.value_out = out_value_reg;
    assign rsp.free_key  = out_free_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            sweep_reg     <= '0;
            lowest_reg    <= LOWEST_RESET;
            highest_reg   <= HIGHEST_RESET;
            upper_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < BGROUPS; i++)
            begin
                big_fill_reg[i] <= '0;
            end
        end
        else
        begin
            upper_reg <= ({1'b0, highest_reg} > cap_top) ? cap_top : {1'b0, highest_reg};
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_LOWEST:  lowest_reg  <= cfg_data;
                    REG_HIGHEST: highest_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (rsp.valid && rsp.ready && (state_reg != S_PUSH))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_CLEAR:
                begin
                    sweep_reg <= sweep_reg + 1'b1;
                    if (sweep_reg == (INDEX_BITS+1)'(CAP - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        op_reg         <= req.opcode;
                        data_reg       <= data_in;
                        idx_reg        <= {1'b0, key_off[INDEX_BITS-1:0]};
                        last_reg       <= upper_reg[INDEX_BITS-1:0] - lowest_reg[INDEX_BITS-1:0];
                        inr_reg        <= (req.key >= lowest_reg) && ({1'b0, req.key} <= upper_reg);
                        res_status_reg <= ST_OK;
                        res_found_reg  <= 1'b0;
                        res_value_reg  <= '0;
                        res_free_reg   <= '0;
                        if (req.opcode == OP_SEARCH)
                        begin
                            state_reg <= S_SRD;
                        end
                        else
                        begin
                            state_reg <= S_READ;
                        end
                    end
                end
                S_READ:
                begin
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    state_reg <= S_PUSH;
                    if (!inr_reg)
                    begin
                        res_status_reg <= ST_INVALID;
                    end
                    else
                    begin
                        unique case (op_reg)
                            OP_LOOKUP:
                            begin
                                res_value_reg  <= rd_wide[WORD_BITS-1:0];
                                res_found_reg  <= !slot_zero;
                                res_status_reg <= slot_zero ? ST_ABSENT : ST_OK;
                            end
                            OP_ADD:
                            begin
                                if (data_reg == '0)
                                begin
                                    res_status_reg <= ST_INVALID;
                                end
                                else if (!slot_zero)
                                begin
                                    res_status_reg <= ST_DENIED;
                                end
                                else
                                begin
                                    big_fill_reg[bg_idx] <= big_fill_reg[bg_idx] + 1'b1;
                                end
                            end
                            OP_REMOVE:
                            begin
                                if (slot_zero)
                                begin
                                    res_status_reg <= ST_ABSENT;
                                end
                                else
                                begin
                                    res_value_reg <= rd_wide[WORD_BITS-1:0];
                                    big_fill_reg[bg_idx] <= big_fill_reg[bg_idx] - 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_SRD:
                begin
                    if (!inr_reg)
                    begin
                        res_status_reg <= ST_INVALID;
                        state_reg      <= S_PUSH;
                    end
                    else if (idx_reg > {1'b0, last_reg})
                    begin
                        res_status_reg <= ST_ABSENT;
                        state_reg      <= S_PUSH;
                    end
                    else
                    begin
                        state_reg <= S_SCHK;
                    end
                end
                S_SCHK:
                begin
                    priority if (big_fill_reg[bg_idx][BS])
                    begin
                        idx_reg   <= (idx_reg & ~(INDEX_BITS+1)'((1 << BS) - 1))
                                     + (INDEX_BITS+1)'(1 << BS);
                        state_reg <= S_SRD;
                    end
                    else if (sg_rdata[SS])
                    begin
                        idx_reg   <= (idx_reg & ~(INDEX_BITS+1)'((1 << SS) - 1))
                                     + (INDEX_BITS+1)'(1 << SS);
                        state_reg <= S_SRD;
                    end
                    else if (slot_zero)
                    begin
                        res_free_reg <= lowest_reg + KEY_W'(idx_reg);
                        state_reg    <= S_PUSH;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_SRD;
                    end
                end
                S_PUSH:
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= res_status_reg;
                        out_found_reg  <= res_found_reg;
                        out_value_reg  <= res_value_reg;
                        out_free_reg   <= res_free_reg;
                        state_reg      <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
